/* rtl/matrix_square_engine_core_assert.svh */
// Assertion macros for the matrix square engine.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef MATRIX_SQUARE_ENGINE_CORE_ASSERT_SVH
`define MATRIX_SQUARE_ENGINE_CORE_ASSERT_SVH

`define MSQE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MSQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msqe_pkg.sv */
// Shared types and constants for the matrix square engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msqe_pkg;

  localparam int DIM_W     = 6;
  localparam int MAX_DIM   = 1 << DIM_W;
  localparam int SIZE_W    = DIM_W + 1;
  localparam int ADDR_W    = 2 * DIM_W;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DATA_W    = 32;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = Q_PTR_W + 1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_RANGE_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_status_t;

endpackage

`default_nettype wire

/* rtl/msqe_front.sv */
// Front end: holds the size register, accepts items and classifies them.
// Depends on msqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msqe_front import msqe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_active_size,
  input  wire logic              in_req_type,
  input  wire logic [DIM_W-1:0]  in_row_index,
  input  wire logic [DIM_W-1:0]  in_col_index,
  input  wire logic [DATA_W-1:0] in_element_value,
  output cmd_t                   cmd
);

  logic [SIZE_W-1:0] active_size_r;
  logic [SIZE_W-1:0] eff_size;
  logic              out_of_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      active_size_r <= cfg_active_size;
    end
  end

  always_comb begin
    eff_size     = (active_size_r > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : active_size_r;
    out_of_range = ({1'b0, in_row_index} >= eff_size) || ({1'b0, in_col_index} >= eff_size);
    cmd.row      = in_row_index;
    cmd.col      = in_col_index;
    cmd.value    = in_element_value;
    cmd.size     = eff_size;
    if (!in_req_type) begin
      cmd.kind = CMD_WRITE;
    end else if (out_of_range) begin
      cmd.kind = CMD_RANGE_ERR;
    end else begin
      cmd.kind = CMD_READ;
    end
  end

endmodule

`default_nettype wire

/* rtl/msqe_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on msqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msqe_fifo import msqe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/msqe_back.sv */
// Back end: matrix store, multiply-accumulate loop and result register.
// Depends on msqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msqe_back import msqe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cmd_t                    head_cmd,
  input  q_status_t               q_status,
  output logic                    pop,
  output back_status_t            status,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DATA_W-1:0]       out_product_value,
  output logic                    out_index_error
);

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  back_state_t       state_r, state_nxt;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [SIZE_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_err_r, out_err_nxt;

  logic              rd_v_r, rd_last_r;
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic              prod_v_r, prod_last_r;
  logic [DATA_W-1:0] prod_r;

  logic              issue;
  logic              issue_last;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  assign issue      = (state_r == BK_CALC) && (iss_cnt_r < n_r);
  assign issue_last = issue && (iss_cnt_r == n_r - 1'b1);
  assign rd_addr_a  = {row_r, iss_cnt_r[DIM_W-1:0]};
  assign rd_addr_b  = {iss_cnt_r[DIM_W-1:0], col_r};
  assign mem_waddr  = {head_cmd.row, head_cmd.col};
  assign mem_wdata  = head_cmd.value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
    prod_r <= rd_a_r * rd_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
    end else begin
      rd_v_r      <= issue;
      rd_last_r   <= issue_last;
      prod_v_r    <= rd_v_r;
      prod_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    acc_r       <= acc_nxt;
    err_r       <= err_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    iss_cnt_nxt   = iss_cnt_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head_cmd.kind)
            CMD_WRITE: begin
              mem_we = 1'b1;
            end
            CMD_READ: begin
              n_nxt       = head_cmd.size;
              row_nxt     = head_cmd.row;
              col_nxt     = head_cmd.col;
              iss_cnt_nxt = '0;
              acc_nxt     = '0;
              err_nxt     = 1'b0;
              state_nxt   = BK_CALC;
            end
            default: begin
              acc_nxt   = '0;
              err_nxt   = 1'b1;
              state_nxt = BK_DONE;
            end
          endcase
        end
      end
      BK_CALC: begin
        if (issue) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (prod_v_r) begin
          acc_nxt = acc_r + prod_r;
          if (prod_last_r) begin
            state_nxt = BK_DONE;
          end
        end
      end
      BK_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = acc_r;
          out_err_nxt   = err_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign status.busy       = (state_r != BK_IDLE);
  assign status.done       = (state_r == BK_DONE);
  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_index_error   = out_err_r;

endmodule

`default_nettype wire

/* rtl/matrix_square_engine_core.sv */
// Top level of the matrix square engine: front end, command queue, back end.
// Depends on msqe_pkg, msqe_front, msqe_fifo, msqe_back and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

// Holds a 64 x 64 matrix of 32-bit elements and returns entries of its square.
// A write item stores one element and leaves the back end in its idle state.
// A read item whose row and column lie inside the active size is worked in
// the back end at one multiply-accumulate per cycle, fed by the two read
// ports of the matrix store, and passes through the read, multiply and
// result-load stages. A read outside the active size returns zero with
// index_error set. Items are carried out strictly in order, one read at a
// time; a four-entry queue lets new items be taken while a read is in
// progress, and the result register lets the next item start while a result
// waits to be taken. Reading an element that was never written returns an
// undefined value. cfg_active_size may be written only while no item is in
// flight; values above 64 act as 64 and zero makes every read fail.

module matrix_square_engine_core import msqe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_active_size,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_req_type,
  input  wire logic [DIM_W-1:0]  in_row_index,
  input  wire logic [DIM_W-1:0]  in_col_index,
  input  wire logic [DATA_W-1:0] in_element_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      out_product_value,
  output logic                   out_index_error
);

`include "matrix_square_engine_core_assert.svh"

  cmd_t         front_cmd;
  cmd_t         head_cmd;
  q_status_t    q_status;
  back_status_t bk_status;
  logic         q_pop;
  logic         in_accept;

  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  msqe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_size  (cfg_active_size),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .cmd              (front_cmd)
  );

  msqe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  msqe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_cmd          (head_cmd),
    .q_status          (q_status),
    .pop               (q_pop),
    .status            (bk_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_index_error   (out_index_error)
  );

  `MSQE_ASSERT_NEXT(a_accept_queued, in_accept, !q_status.empty, "accepted item not queued")
  `MSQE_ASSERT_SAME(a_err_zero, out_valid && out_index_error, out_product_value == '0, "index error with nonzero value")
  `MSQE_ASSERT_SAME(a_rise_from_done, $rose(out_valid), $past(bk_status.done), "result without finished work")
  `MSQE_ASSERT_SAME(a_pop_idle, q_pop, !bk_status.busy, "queue popped while back end busy")

endmodule

`default_nettype wire
